/* rtl/psgc_pkg.sv */
`timescale 1ns / 1ps

package psgc_pkg;

    // table size and field widths
    localparam int TABLE_ENTRIES  = 32;
    localparam int ID_W           = 32;
    localparam int SEQ_W          = 32;
    localparam int CNT_W          = 32;
    localparam int TICK_W         = 12;
    localparam logic [TICK_W-1:0] INTERVAL_RESET = 12'd30;

    // action codes
    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // command broadcast to every cell of the table
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [SEQ_W-1:0] seq;
        logic             lookup;    // capture the tag compare
        logic             wr_hit;    // matching cell takes the new sequence
        logic             wr_claim;  // first free cell takes id and sequence
    } psgc_cmd_t;

endpackage

/* rtl/psgc_cell.sv */
`timescale 1ns / 1ps

module psgc_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  psgc_pkg::psgc_cmd_t         cmd,
    input  logic                        prev_used,   // from the left neighbor
    output logic                        used_out,    // to the right neighbor
    output logic                        hit_out,
    output logic [psgc_pkg::SEQ_W-1:0]  seq_out      // zero unless hit
);

    logic [psgc_pkg::ID_W-1:0]  id_reg;
    logic [psgc_pkg::SEQ_W-1:0] seq_reg;
    logic                       used_reg;   // slot in use, sequence already seen
    logic                       hit_reg;
    logic                       first_free;
    logic                       take_claim;

    // the free cell right after the last used one is the next slot
    assign first_free = prev_used && !used_reg;
    assign take_claim = cmd.wr_claim && first_free;

    assign used_out = used_reg;
    assign hit_out  = hit_reg;
    assign seq_out  = hit_reg ? seq_reg : '0;

    // control bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end else begin
            if (cmd.lookup) begin
                hit_reg <= used_reg && (id_reg == cmd.id);
            end
            if (take_claim) begin
                used_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (take_claim) begin
            id_reg <= cmd.id;
        end
        if (take_claim || (cmd.wr_hit && hit_reg)) begin
            seq_reg <= cmd.seq;
        end
    end

endmodule

/* rtl/per_sender_sequence_gap_counter.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata = sender_id, sequence_req; s_tuser = action
// m_       out  m_tvalid/m_tready  m_tdata = gap_found, drop_total_now, summary_count;
//                                  m_tuser = tracked, summary_due
// cfg_     in   cfg_wr_en          cfg_wr_data = summary_interval
//
// Each item passes through accept, tag compare in every cell, reduce of the
// matching cell's sequence with gap compute, then commit of counters and cells.
// The commit waits while the output register holds an item not yet taken.
// A new item is accepted only after the commit; a waiting result does not block it.
// Reset (aresetn low, synchronous) clears all slot-in-use bits and counters.

module per_sender_sequence_gap_counter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // [31:0] sender_id, [63:32] sequence_req
    input  logic        s_tuser,     // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,     // [31:0] gap_found, [63:32] drop_total_now,
                                     // [95:64] summary_count
    output logic [1:0]  m_tuser,     // [0] tracked, [1] summary_due
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data  // [11:0] summary_interval
);

    localparam int N = psgc_pkg::TABLE_ENTRIES;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_CALC, S_RES} state_t;

    state_t                          state_reg;
    logic                            act_reg;
    logic [psgc_pkg::ID_W-1:0]       id_reg;
    logic [psgc_pkg::SEQ_W-1:0]      seq_reg;
    logic [psgc_pkg::TICK_W-1:0]     interval_reg;
    logic [psgc_pkg::TICK_W-1:0]     ticks_reg;
    logic [psgc_pkg::TICK_W-1:0]     ticks_next;
    logic [psgc_pkg::CNT_W-1:0]      total_reg;
    logic [psgc_pkg::CNT_W-1:0]      total_next;
    logic [psgc_pkg::CNT_W-1:0]      period_reg;
    logic [psgc_pkg::CNT_W-1:0]      gap_reg;
    logic [psgc_pkg::CNT_W-1:0]      gap_next;
    logic                            hit_reg;
    logic                            full_reg;
    logic                            due;
    logic                            advance;
    logic                            m_tvalid_reg;
    logic [95:0]                     m_tdata_reg;
    logic [1:0]                      m_tuser_reg;

    psgc_pkg::psgc_cmd_t             cmd;
    logic [N:0]                      used_chain;
    logic [N-1:0]                    hits;
    logic [psgc_pkg::SEQ_W-1:0]      cell_seq [N];
    logic [psgc_pkg::SEQ_W-1:0]      stored_seq;
    logic                            any_hit;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // commit only when the output register can take the result
    assign advance = (state_reg == S_RES) && (!m_tvalid_reg || m_tready);

    // cell row; the chain carries slot-in-use from cell to cell
    assign used_chain[0] = 1'b1;
    assign cmd.id        = id_reg;
    assign cmd.seq       = seq_reg;
    assign cmd.lookup    = (state_reg == S_LOOK);
    assign cmd.wr_hit    = advance && (act_reg == psgc_pkg::ACT_RECORD) && hit_reg;
    assign cmd.wr_claim  = advance && (act_reg == psgc_pkg::ACT_RECORD) && !hit_reg
                           && !full_reg;

    for (genvar g = 0; g < N; g++) begin : g_cell
        psgc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .prev_used (used_chain[g]),
            .used_out  (used_chain[g+1]),
            .hit_out   (hits[g]),
            .seq_out   (cell_seq[g])
        );
    end

    // at most one cell hits, so an OR picks its sequence
    always_comb begin
        stored_seq = '0;
        for (int i = 0; i < N; i++) begin
            stored_seq = stored_seq | cell_seq[i];
        end
    end
    assign any_hit = |hits;

    // forward jump of more than one counts the missing records
    always_comb begin
        gap_next = '0;
        if (any_hit && (seq_reg > stored_seq) && (seq_reg != stored_seq + 32'd1)) begin
            gap_next = seq_reg - stored_seq - 32'd1;
        end
    end

    // tick counter and totals
    always_comb begin
        ticks_next = ticks_reg + 12'd1;
        due        = (act_reg == psgc_pkg::ACT_TICK) && (ticks_next >= interval_reg);
        total_next = total_reg + gap_reg;
    end

    // sequencer, counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            interval_reg <= psgc_pkg::INTERVAL_RESET;
            ticks_reg    <= '0;
            total_reg    <= '0;
            period_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                interval_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready && !advance) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    state_reg <= S_CALC;
                end
                S_CALC: begin
                    state_reg <= S_RES;
                end
                S_RES: begin
                    if (advance) begin
                        state_reg    <= S_IDLE;
                        m_tvalid_reg <= 1'b1;
                        if (act_reg == psgc_pkg::ACT_RECORD) begin
                            total_reg   <= total_next;
                            period_reg  <= period_reg + gap_reg;
                            m_tdata_reg <= {32'd0, total_next, gap_reg};
                            m_tuser_reg <= {1'b0, hit_reg || !full_reg};
                        end else begin
                            m_tdata_reg <= {(due ? period_reg : 32'd0), total_reg, 32'd0};
                            m_tuser_reg <= {due, 1'b0};
                            if (due) begin
                                period_reg <= '0;
                                ticks_reg  <= '0;
                            end else begin
                                ticks_reg  <= ticks_next;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item capture and compare results
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg <= s_tuser;
            id_reg  <= s_tdata[31:0];
            seq_reg <= s_tdata[63:32];
        end
        if (state_reg == S_CALC) begin
            gap_reg  <= gap_next;
            hit_reg  <= any_hit;
            full_reg <= used_chain[N];
        end
    end

endmodule

/* rtl/psgc_checker.sv */
`timescale 1ns / 1ps

module psgc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // a record is never a summary
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("tracked and summary_due together");

    // summary count only with summary_due
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[95:64] == 32'd0)
        else $error("summary_count without summary_due");

    // a gap needs a tracked sender
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[31:0] != 32'd0) |-> m_tuser[0])
        else $error("gap on untracked sender");

endmodule

bind per_sender_sequence_gap_counter psgc_checker u_psgc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* sim/per_sender_sequence_gap_counter_tb.sv */
`timescale 1ns / 1ps

module per_sender_sequence_gap_counter_tb;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TICKS = 16;
    localparam int POOL_SIZE    = 40;

    // one result item, split into its fields
    typedef struct packed {
        logic                        tracked;
        logic [psgc_pkg::CNT_W-1:0]  gap;
        logic [psgc_pkg::CNT_W-1:0]  total;
        logic                        due;
        logic [psgc_pkg::CNT_W-1:0]  count;
    } gap_report_t;

    // mirror of the sender table and drop counters, plus the results still owed
    class gap_ledger;
        logic [psgc_pkg::ID_W-1:0]   sender_tag[psgc_pkg::TABLE_ENTRIES];
        logic [psgc_pkg::SEQ_W-1:0]  slot_seq[psgc_pkg::TABLE_ENTRIES];
        bit                          seq_valid[psgc_pkg::TABLE_ENTRIES];
        int unsigned                 slots_used;
        logic [psgc_pkg::CNT_W-1:0]  drops_total;
        logic [psgc_pkg::CNT_W-1:0]  drops_period;
        logic [psgc_pkg::TICK_W-1:0] tick_count;
        logic [psgc_pkg::TICK_W-1:0] interval;
        gap_report_t                 expected_reports[$];
        int                          errors;

        function new();
            interval     = psgc_pkg::INTERVAL_RESET;
            slots_used   = 0;
            drops_total  = '0;
            drops_period = '0;
            tick_count   = '0;
            errors       = 0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // advance the mirror by one accepted item and return what it should report
        function gap_report_t account(logic action, logic [psgc_pkg::ID_W-1:0] id,
                                      logic [psgc_pkg::SEQ_W-1:0] seq);
            gap_report_t r;
            int slot;
            logic [psgc_pkg::TICK_W-1:0] next_tick;
            r = '0;
            slot = -1;
            if (action == psgc_pkg::ACT_RECORD) begin
                for (int i = 0; i < slots_used; i++) begin
                    if (slot < 0 && sender_tag[i] == id) slot = i;
                end
                // new sender claims the next free slot, if any
                if (slot < 0 && slots_used < psgc_pkg::TABLE_ENTRIES) begin
                    slot = slots_used;
                    sender_tag[slot] = id;
                    seq_valid[slot] = 1'b0;
                    slots_used++;
                end
                if (slot >= 0) begin
                    r.tracked = 1'b1;
                    // forward jump by more than one counts the missing records
                    if (seq_valid[slot] && seq > slot_seq[slot] &&
                        seq != slot_seq[slot] + 32'd1) begin
                        r.gap = seq - slot_seq[slot] - 32'd1;
                        drops_total  += r.gap;
                        drops_period += r.gap;
                    end
                    slot_seq[slot]  = seq;
                    seq_valid[slot] = 1'b1;
                end
            end else begin
                next_tick = tick_count + 1'b1;
                if (next_tick >= interval) begin
                    r.due = 1'b1;
                    r.count = drops_period;
                    drops_period = '0;
                    next_tick = '0;
                end
                tick_count = next_tick;
            end
            r.total = drops_total;
            return r;
        endfunction

        function void record_sent(logic action, logic [psgc_pkg::ID_W-1:0] id,
                                  logic [psgc_pkg::SEQ_W-1:0] seq);
            expected_reports.push_back(account(action, id, seq));
        endfunction

        function void compare_result(logic [95:0] data, logic [1:0] user);
            gap_report_t want;
            if (expected_reports.size() == 0) begin
                $error("result item with none expected: tdata %h tuser %b", data, user);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            if (user[0] !== want.tracked) begin
                $error("tracked: expected %0d, actual %0d", want.tracked, user[0]);
                errors++;
            end
            if (data[31:0] !== want.gap) begin
                $error("gap_found: expected %0d, actual %0d", want.gap, data[31:0]);
                errors++;
            end
            if (data[63:32] !== want.total) begin
                $error("drop_total_now: expected %0d, actual %0d", want.total, data[63:32]);
                errors++;
            end
            if (user[1] !== want.due) begin
                $error("summary_due: expected %0d, actual %0d", want.due, user[1]);
                errors++;
            end
            if (data[95:64] !== want.count) begin
                $error("summary_count: expected %0d, actual %0d", want.count, data[95:64]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;     // [31:0] sender_id, [63:32] sequence_req
    logic        s_tuser = 1'b0;   // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;          // [31:0] gap_found, [63:32] drop_total_now,
                                   // [95:64] summary_count
    logic [1:0]  m_tuser;          // [0] tracked, [1] summary_due
    logic        cfg_wr_en = 1'b0;
    logic [11:0] cfg_wr_data = '0; // [11:0] summary_interval

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cycles = 0;
    gap_ledger   ledger;

    // generator's view of the senders it talks for
    logic [psgc_pkg::ID_W-1:0]  id_pool[POOL_SIZE];
    logic [psgc_pkg::SEQ_W-1:0] pool_last[POOL_SIZE];
    bit                         pool_sent[POOL_SIZE];

    per_sender_sequence_gap_counter DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("per_sender_sequence_gap_counter regression: fail");
            $finish;
        end
    end

    // result side: check on handshake, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) ledger.compare_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // offer one item, with random idle cycles ahead of it
    task automatic send_item(logic action, logic [psgc_pkg::ID_W-1:0] id,
                             logic [psgc_pkg::SEQ_W-1:0] seq);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {seq, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ledger.record_sent(action, id, seq);
    endtask

    // hold off the sender until every owed result is out, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_interval(logic [psgc_pkg::TICK_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ledger.interval = value;
    endtask

    // mostly in-order sequences from a fixed set of senders, some gaps and noise
    task automatic run_random(int count);
        int k;
        int pick;
        logic [psgc_pkg::SEQ_W-1:0] seq;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 20) begin
                send_item(psgc_pkg::ACT_TICK, $urandom, $urandom);
            end else if ($urandom_range(0, 99) < 5) begin
                send_item(psgc_pkg::ACT_RECORD, $urandom, $urandom);
            end else begin
                k = $urandom_range(0, POOL_SIZE - 1);
                pick = $urandom_range(0, 99);
                if (!pool_sent[k] || pick >= 95) seq = $urandom;
                else if (pick < 60) seq = pool_last[k] + 32'd1;
                else if (pick < 75) seq = pool_last[k] + $urandom_range(2, 40);
                else if (pick < 82) seq = pool_last[k];
                else if (pick < 88) seq = pool_last[k] - $urandom_range(1, 40);
                else if (pick < 92) seq = 32'hFFFF_FFFF;
                else seq = pool_last[k] + $urandom;
                pool_sent[k] = 1'b1;
                pool_last[k] = seq;
                send_item(psgc_pkg::ACT_RECORD, id_pool[k], seq);
            end
        end
    endtask

    initial begin
        ledger = new();
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;

        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 11;
        recv_idle_pct = 83;

        // directed: first record, steps, gaps, repeats, wrap of the total
        send_item(psgc_pkg::ACT_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(psgc_pkg::ACT_RECORD, 32'h0000_0000, 32'h0000_0000);
        send_item(psgc_pkg::ACT_RECORD, 32'h0000_0000, 32'h0000_0001);
        send_item(psgc_pkg::ACT_RECORD, 32'h0000_0000, 32'h0000_0005);
        send_item(psgc_pkg::ACT_RECORD, 32'h0000_0000, 32'h0000_0005);
        send_item(psgc_pkg::ACT_RECORD, 32'h0000_0000, 32'h0000_0002);
        send_item(psgc_pkg::ACT_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(psgc_pkg::ACT_RECORD, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(psgc_pkg::ACT_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(psgc_pkg::ACT_RECORD, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(psgc_pkg::ACT_RECORD, 32'h0000_0000, 32'h0000_0000);
        send_item(psgc_pkg::ACT_TICK, 32'h0000_0000, 32'h0000_0000);

        write_interval(12'd1);
        run_random(200);
        write_interval(12'd7);
        run_random(250);

        // roles swapped
        send_idle_pct = 83;
        recv_idle_pct = 11;
        write_interval(12'd30);
        run_random(250);
        // likely below the running tick count
        write_interval(12'd3);
        run_random(200);
        write_interval(12'd0);
        run_random(150);

        // no idling; long interval, then one set below the running count
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_interval(12'd4095);
        run_random(300);
        write_interval(12'd12);
        run_random(100);

        drain();
        if (ledger.errors == 0 && ledger.pending() == 0) begin
            $display("per_sender_sequence_gap_counter regression: pass");
        end else begin
            $display("per_sender_sequence_gap_counter regression: fail");
        end
        $finish;
    end

endmodule
